// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

  // Frame layout: header, address, id, length, data..., check 1, check 2
  localparam int unsigned MaxFrameBytes = 64;
  localparam int unsigned HeadBytes     = 4;
  localparam int unsigned FrameOverhead = HeadBytes + 2;
  localparam logic [8:0]  LenLimit      = 9'(MaxFrameBytes - FrameOverhead);

  localparam logic [7:0] HeaderReset  = 8'd170;
  localparam logic [7:0] AddressReset = 8'd255;
  localparam logic [7:0] MaxLenReset  = 8'd58;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHeader  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAddress = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxLen  = 2'd2;

  localparam logic KindData   = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhAddr = 3'd1,
    PhId   = 3'd2,
    PhLen  = 3'd3,
    PhData = 3'd4,
    PhChk1 = 3'd5,
    PhChk2 = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] address;
    logic [7:0] max_len;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] data_count;
    logic [7:0] declared_length;
    logic [7:0] held_id;
    logic [7:0] sum;
    logic [7:0] sum_of_sums;
    logic [7:0] first_check;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] msg_id;
    logic [7:0] frame_length;
    logic       check_ok;
  } result_t;

endpackage

// ===== rtl/sfr_parser.sv =====
module sfr_parser (
  input  sfr_pkg::state_t  state_i,
  input  sfr_pkg::cfg_t    cfg_i,
  input  logic [7:0]       rx_byte_i,
  output sfr_pkg::state_t  state_o,
  output logic             emit_o,
  output sfr_pkg::result_t result_o
);

  logic [7:0] sum_acc;
  logic [7:0] sos_acc;
  logic [7:0] cnt_inc;
  logic       len_ok;

  assign sum_acc = state_i.sum + rx_byte_i;
  assign sos_acc = state_i.sum_of_sums + sum_acc;
  assign cnt_inc = state_i.data_count + 8'd1;
  assign len_ok  = ({1'b0, rx_byte_i} <= {1'b0, cfg_i.max_len})
                && ({1'b0, rx_byte_i} <= sfr_pkg::LenLimit);

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{kind:         sfr_pkg::KindData,
                 data_byte:    8'd0,
                 data_index:   8'd0,
                 msg_id:       state_i.held_id,
                 frame_length: state_i.declared_length,
                 check_ok:     1'b0};
    case (state_i.phase)
      sfr_pkg::PhAddr: begin
        state_o.sum         = sum_acc;
        state_o.sum_of_sums = sos_acc;
        state_o.phase = (rx_byte_i == cfg_i.address) ? sfr_pkg::PhId : sfr_pkg::PhHunt;
      end
      sfr_pkg::PhId: begin
        state_o.sum         = sum_acc;
        state_o.sum_of_sums = sos_acc;
        state_o.held_id     = rx_byte_i;
        state_o.phase       = sfr_pkg::PhLen;
      end
      sfr_pkg::PhLen: begin
        state_o.sum             = sum_acc;
        state_o.sum_of_sums     = sos_acc;
        state_o.declared_length = rx_byte_i;
        state_o.data_count      = 8'd0;
        if (rx_byte_i == 8'd0) begin
          state_o.phase = sfr_pkg::PhChk1;
        end else if (len_ok) begin
          state_o.phase = sfr_pkg::PhData;
        end else begin
          state_o.phase = sfr_pkg::PhHunt;
        end
      end
      sfr_pkg::PhData: begin
        state_o.sum          = sum_acc;
        state_o.sum_of_sums  = sos_acc;
        emit_o               = 1'b1;
        result_o.data_byte   = rx_byte_i;
        result_o.data_index  = state_i.data_count;
        state_o.data_count   = cnt_inc;
        if (cnt_inc >= state_i.declared_length) begin
          state_o.phase = sfr_pkg::PhChk1;
        end
      end
      sfr_pkg::PhChk1: begin
        state_o.first_check = rx_byte_i;
        state_o.phase       = sfr_pkg::PhChk2;
      end
      sfr_pkg::PhChk2: begin
        emit_o            = 1'b1;
        result_o.kind     = sfr_pkg::KindReport;
        result_o.check_ok = (state_i.first_check == state_i.sum)
                         && (rx_byte_i == state_i.sum_of_sums);
        state_o.phase     = sfr_pkg::PhHunt;
      end
      default: begin
        // hunt: restart both sums on a header byte
        state_o.phase = sfr_pkg::PhHunt;
        if (rx_byte_i == cfg_i.header) begin
          state_o.sum         = rx_byte_i;
          state_o.sum_of_sums = rx_byte_i;
          state_o.data_count  = 8'd0;
          state_o.phase       = sfr_pkg::PhAddr;
        end
      end
    endcase
  end

endmodule

// ===== rtl/serial_frame_receiver_core.sv =====
// Serial frame receiver core.
// Slave stream: one received byte per beat on s_axis_tdata_i. The receiver hunts
// for a header, checks the address and length, then passes data bytes on.
// Master stream: one beat per data byte (tuser = 0) carrying the byte and its
// index, and one report beat after the second check byte (tuser = 1) with the
// id byte, declared length and the combined sum / sum-of-sums check result.
// Header, address, id and length bytes and the first check byte give no beat.
// Configuration: cfg_we_i writes register cfg_addr_i (0 header byte, 1 target
// address, 2 max data length); write only while no beat is in flight.
// Output: a result is registered and appears on the master side in the cycle
// after its input beat is taken. Throughput: one byte per cycle while tready is
// high, set by the combinational update of the phase and running sums.
// Stall: a single output register holds the pending result; a new byte is still
// taken in the cycle the master side drains it, and tready drops only while
// that register is full and not being read.
// Reset: phase returns to hunting, sums and counters clear, and the registers
// take their defaults (header 170, address 255, max length 58).
module serial_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] data_index,
                                        // [23:16] msg_id, [31:24] frame_length,
                                        // [32] check_ok, [39:33] zero
  output logic        m_axis_tuser_o,   // [0] result_kind
  input  logic        cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i
);

  sfr_pkg::cfg_t    cfg_q;
  sfr_pkg::state_t  state_q, state_d;
  sfr_pkg::result_t res_d, res_q;
  logic             emit_d;
  logic             out_valid_q;
  logic             in_fire;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header  <= sfr_pkg::HeaderReset;
      cfg_q.address <= sfr_pkg::AddressReset;
      cfg_q.max_len <= sfr_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sfr_pkg::CfgHeader:  cfg_q.header  <= cfg_wdata_i;
        sfr_pkg::CfgAddress: cfg_q.address <= cfg_wdata_i;
        sfr_pkg::CfgMaxLen:  cfg_q.max_len <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sfr_parser u_parser (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .rx_byte_i (s_axis_tdata_i),
    .state_o   (state_d),
    .emit_o    (emit_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: sfr_pkg::PhHunt, default: '0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit_d) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: load only when a new result is produced
  always_ff @(posedge clk_i) begin
    if (in_fire && emit_d) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tdata_o  = {7'd0, res_q.check_ok, res_q.frame_length, res_q.msg_id,
                            res_q.data_index, res_q.data_byte};

endmodule

// ===== tb/serial_frame_receiver_core_tb.sv =====
`timescale 1ns / 100ps

module serial_frame_receiver_core_tb;

  localparam logic [sfr_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned RandomBytes = 360;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [sfr_pkg::CfgIdxW-1:0] cfg_addr_i = sfr_pkg::CfgHeader;
  logic [7:0]  cfg_wdata_i = 8'h00;

  serial_frame_receiver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver copy of the registers and of the frame tracking state
  sfr_pkg::cfg_t   regs = '{header: sfr_pkg::HeaderReset, address: sfr_pkg::AddressReset,
                            max_len: sfr_pkg::MaxLenReset};
  sfr_pkg::phase_e rx_ph = sfr_pkg::PhHunt;
  logic [7:0] n_data = 8'h00;
  logic [7:0] decl_len = 8'h00;
  logic [7:0] cur_id = 8'h00;
  logic [7:0] sum8 = 8'h00;
  logic [7:0] sos8 = 8'h00;
  logic [7:0] chk_a = 8'h00;

  sfr_pkg::result_t pending_beats[$];
  int      fails = 0;
  int      bytes_sent = 0;
  bit      idle_en = 1'b1;

  function automatic void add_to_sums(input logic [7:0] b);
    sum8 = sum8 + b;
    sos8 = sos8 + sum8;
  endfunction

  // Advance the frame tracker by one received byte, queue the beat it produces
  function automatic void track_rx_byte(input logic [7:0] b);
    sfr_pkg::result_t r;
    r = '0;
    r.msg_id       = cur_id;
    r.frame_length = decl_len;
    case (rx_ph)
      sfr_pkg::PhAddr: begin
        add_to_sums(b);
        rx_ph = (b == regs.address) ? sfr_pkg::PhId : sfr_pkg::PhHunt;
      end
      sfr_pkg::PhId: begin
        add_to_sums(b);
        cur_id = b;
        rx_ph  = sfr_pkg::PhLen;
      end
      sfr_pkg::PhLen: begin
        add_to_sums(b);
        decl_len = b;
        n_data   = 8'h00;
        if (b == 8'h00) rx_ph = sfr_pkg::PhChk1;
        else if (b <= regs.max_len && 9'(b) <= sfr_pkg::LenLimit) rx_ph = sfr_pkg::PhData;
        else rx_ph = sfr_pkg::PhHunt;
      end
      sfr_pkg::PhData: begin
        add_to_sums(b);
        r.kind       = sfr_pkg::KindData;
        r.data_byte  = b;
        r.data_index = n_data;
        pending_beats.push_back(r);
        n_data = n_data + 8'd1;
        if (n_data >= decl_len) rx_ph = sfr_pkg::PhChk1;
      end
      sfr_pkg::PhChk1: begin
        chk_a = b;
        rx_ph = sfr_pkg::PhChk2;
      end
      sfr_pkg::PhChk2: begin
        r.kind     = sfr_pkg::KindReport;
        r.check_ok = (chk_a == sum8) && (b == sos8);
        pending_beats.push_back(r);
        rx_ph = sfr_pkg::PhHunt;
      end
      default: begin
        rx_ph = sfr_pkg::PhHunt;
        if (b == regs.header) begin
          sum8   = 8'h00;
          sos8   = 8'h00;
          n_data = 8'h00;
          add_to_sums(b);
          rx_ph = sfr_pkg::PhAddr;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) m_axis_tready_i <= !(idle_en && $urandom_range(0, 99) < 8);

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : check_beats
    sfr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with no expected result pending");
        fails++;
      end else begin
        want = pending_beats.pop_front();
        cmp_field("result_kind", 8'(want.kind), 8'(m_axis_tuser_o));
        cmp_field("data_byte", want.data_byte, m_axis_tdata_o[7:0]);
        cmp_field("data_index", want.data_index, m_axis_tdata_o[15:8]);
        cmp_field("msg_id", want.msg_id, m_axis_tdata_o[23:16]);
        cmp_field("frame_length", want.frame_length, m_axis_tdata_o[31:24]);
        cmp_field("check_ok", 8'(want.check_ok), 8'(m_axis_tdata_o[32]));
        cmp_field("pad", 8'h00, 8'(m_axis_tdata_o[39:33]));
      end
    end
  end

  // Leave tvalid as is on return so back-to-back beats need no extra assignment
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  // bad_check: 0 both check bytes right, 1 corrupt the first, 2 corrupt the second
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] id,
                            input logic [7:0] len, input int bad_check);
    logic [7:0] body[$];
    logic [7:0] s;
    logic [7:0] ss;
    int         n_payload;
    body = '{regs.header, addr, id, len};
    // A length past any limit drops the frame, so keep the trailing bytes short
    n_payload = (len > 60) ? 8 : int'(len);
    repeat (n_payload) body.push_back(8'($urandom));
    s  = 8'h00;
    ss = 8'h00;
    foreach (body[i]) begin
      s  = s + body[i];
      ss = ss + s;
    end
    if (bad_check == 1) s = s ^ 8'(1 << $urandom_range(0, 7));
    if (bad_check == 2) ss = ss ^ 8'(1 << $urandom_range(0, 7));
    foreach (body[i]) send_byte(body[i]);
    send_byte(s);
    send_byte(ss);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Caller holds cfg_we_i high around a run of these
  task automatic put_reg(input logic [sfr_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      sfr_pkg::CfgHeader:  regs.header  = val;
      sfr_pkg::CfgAddress: regs.address = val;
      sfr_pkg::CfgMaxLen:  regs.max_len = val;
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [7:0] hdr, input logic [7:0] addr,
                            input logic [7:0] max_len);
    wait_quiet();
    cfg_we_i <= 1'b1;
    put_reg(sfr_pkg::CfgHeader, hdr);
    put_reg(sfr_pkg::CfgAddress, addr);
    put_reg(sfr_pkg::CfgMaxLen, max_len);
    // Index past the register list must not disturb anything
    put_reg(CfgUnused, 8'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_frame(sfr_pkg::AddressReset, 8'h00, 8'd0, 0);
    send_frame(sfr_pkg::AddressReset, 8'hFF, 8'd1, 0);
  endtask

  task automatic test_dropped_frames();
    // Mismatching address equal to the header byte must not restart a frame
    send_byte(regs.header);
    send_byte(regs.header);
    send_byte(8'h00);
    send_frame(regs.address, 8'h5A, 8'd2, 0);
    send_frame(regs.address, 8'hA5, 8'd59, 0);
    send_frame(regs.address, 8'h3C, 8'd0, 0);
  endtask

  task automatic test_bad_checks();
    send_frame(regs.address, 8'h11, 8'd2, 1);
    send_frame(regs.address, 8'h22, 8'd1, 2);
  endtask

  task automatic sweep_lengths();
    logic [7:0] lens[6];
    lens = '{8'd0, 8'd1, regs.max_len, regs.max_len + 8'd1, 8'd58, 8'd59};
    foreach (lens[i]) send_frame(regs.address, 8'($urandom), lens[i], $urandom_range(0, 2));
  endtask

  task automatic test_register_writes();
    write_regs(8'h00, 8'h00, 8'h00);
    sweep_lengths();
    write_regs(8'hFF, 8'hFF, 8'hFF);
    sweep_lengths();
    write_regs(8'($urandom), 8'($urandom), 8'd57);
    sweep_lengths();
    // Change the registers between the address and id bytes of a frame
    send_byte(regs.header);
    send_byte(regs.address);
    wait_quiet();
    cfg_we_i <= 1'b1;
    put_reg(sfr_pkg::CfgMaxLen, 8'd3);
    put_reg(sfr_pkg::CfgHeader, 8'h7E);
    cfg_we_i <= 1'b0;
    send_byte(8'h44);
    send_byte(8'd4);
    send_frame(regs.address, 8'h45, 8'd3, 0);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int         pick;
    logic [7:0] lim;
    logic [7:0] len;
    int         stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      lim  = (regs.max_len < 8'(sfr_pkg::LenLimit)) ? regs.max_len : 8'(sfr_pkg::LenLimit);
      if (pick < 85) begin
        case ($urandom_range(0, 9))
          0, 1:    len = 8'($urandom_range(int'(lim) > 0 ? int'(lim) - 1 : 0, int'(lim) + 1));
          2:       len = 8'($urandom);
          default: len = 8'($urandom_range(0, 8));
        endcase
        send_frame(($urandom_range(0, 9) < 8) ? regs.address : 8'($urandom),
                   8'($urandom), len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      end else if (pick < 93) begin
        // Broken frame: start it, then cut it short
        send_byte(regs.header);
        send_byte(regs.address);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_dropped_frames();
    test_bad_checks();
    test_register_writes();
    write_regs(sfr_pkg::HeaderReset, sfr_pkg::AddressReset, sfr_pkg::MaxLenReset);
    test_random_traffic(RandomBytes / 3);
    write_regs(8'($urandom), 8'($urandom), 8'($urandom_range(0, 70)));
    idle_en = 1'b0;
    test_random_traffic(RandomBytes / 3);
    wait_quiet();
    idle_en = 1'b1;
    write_regs(8'($urandom), 8'($urandom), 8'($urandom_range(0, 70)));
    test_random_traffic(RandomBytes / 3);
    wait_quiet();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfr_pkg.sv
rtl/sfr_parser.sv
rtl/serial_frame_receiver_core.sv
tb/serial_frame_receiver_core_tb.sv
